// File: rtl/core/lsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types, sizes and helpers of the LRU slot allocator.
// ----------------------------------------------------------------------------
package lsa_pkg;

    localparam int LAST_SLOT = 15;
    localparam int NSLOTS    = LAST_SLOT + 1;
    localparam int KEY_BYTES = 8;
    localparam int KEY_W     = 64;
    localparam int AGE_W     = 31;
    localparam int SLOT_W    = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int FILL_W    = $clog2(NSLOTS + 1);
    localparam int GRANT_W   = 4;
    localparam int OUT_W     = 8;

    localparam int unsigned AGE_LIMIT = 32'h7FFF_FFFF;
    localparam logic [AGE_W-1:0] RENUM_AT = AGE_W'(AGE_LIMIT - LAST_SLOT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic              key_we;
        logic              age_we;
        logic [SLOT_W-1:0] addr;
        logic [KEY_W-1:0]  key;
        logic [AGE_W-1:0]  age;
    } tbl_wr_t;

    typedef struct packed {
        logic              en;
        logic              renum;
        logic [SLOT_W-1:0] idx;
    } scan_ctl_t;

    // keep bytes from the top down until the first zero byte or KEY_BYTES
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] res;
        logic             live;
        res  = '0;
        live = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (i >= KEY_BYTES) begin
                live = 1'b0;
            end else if (k[56-8*i +: 8] == 8'h00) begin
                live = 1'b0;
            end
            if (live) begin
                res[56-8*i +: 8] = k[56-8*i +: 8];
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/lru_slot_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_slot_allocator_top
// Grants each incoming key a slot of a 16-entry LRU table.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one key per request; output stream m_axis
// returns the granted slot with replacement and restamp flags.
// Until all slots are in use a request takes the next free slot and goes
// to ST_WRITE, which raises m_axis_tvalid; the next request waits for ST_IDLE.
// Once the table is full, or when the age counter reaches its restamp
// point, a walk over all 16 slots runs through the shared compare unit,
// one slot per cycle, and the request's write step follows that walk.
// s_axis_tready is high only while the block is idle.
// A result waits in the output register while m_axis_tready is low; the
// next request is still accepted and its write stalls until the
// register is free.
// Reset (aresetn low, synchronous) clears the fill count, age counter and
// output valid; the slot table itself has no reset.
// ----------------------------------------------------------------------------
module lru_slot_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] new_key
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [3:0] granted_slot, [4] was_replacement,
                                        // [5] ages_renumbered, [7:6] zero
);

    lsa_pkg::tbl_wr_t            tbl_wr;
    lsa_pkg::scan_ctl_t          scan_ctl;
    logic [lsa_pkg::KEY_W-1:0]   rd_key;
    logic [lsa_pkg::AGE_W-1:0]   rd_age;
    logic [lsa_pkg::SLOT_W-1:0]  best_idx;

    lsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .tbl_wr   (tbl_wr),
        .scan_ctl (scan_ctl),
        .best_idx (best_idx)
    );

    lsa_slot_table u_table (
        .aclk   (aclk),
        .wr     (tbl_wr),
        .rd_idx (scan_ctl.idx),
        .rd_key (rd_key),
        .rd_age (rd_age)
    );

    lsa_victim_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (scan_ctl),
        .rd_key   (rd_key),
        .rd_age   (rd_age),
        .best_idx (best_idx)
    );

endmodule

// File: rtl/core/lsa_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_slot_table
// Key and age storage of all slots, one write port and one read port.
// ----------------------------------------------------------------------------
module lsa_slot_table (
    input  logic                          aclk,
    input  lsa_pkg::tbl_wr_t              wr,
    input  logic [lsa_pkg::SLOT_W-1:0]    rd_idx,
    output logic [lsa_pkg::KEY_W-1:0]     rd_key,
    output logic [lsa_pkg::AGE_W-1:0]     rd_age
);

    logic [lsa_pkg::KEY_W-1:0] key_reg [lsa_pkg::NSLOTS];
    logic [lsa_pkg::AGE_W-1:0] age_reg [lsa_pkg::NSLOTS];

    // slots are filled in order before any scan reads them
    always_ff @(posedge aclk) begin
        if (wr.key_we) begin
            key_reg[wr.addr] <= wr.key;
        end
        if (wr.age_we) begin
            age_reg[wr.addr] <= wr.age;
        end
    end

    assign rd_key = key_reg[rd_idx];
    assign rd_age = age_reg[rd_idx];

endmodule

// File: rtl/core/lsa_victim_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_victim_scan
// Shared compare unit: walks one slot per cycle, tracks first empty slot or
// the oldest age (lowest index on ties).
// ----------------------------------------------------------------------------
module lsa_victim_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lsa_pkg::scan_ctl_t            ctl,
    input  logic [lsa_pkg::KEY_W-1:0]     rd_key,
    input  logic [lsa_pkg::AGE_W-1:0]     rd_age,
    output logic [lsa_pkg::SLOT_W-1:0]    best_idx
);

    logic [lsa_pkg::SLOT_W-1:0] best_idx_reg;
    logic [lsa_pkg::AGE_W-1:0]  best_age_reg;
    logic                       found_reg;
    logic [lsa_pkg::AGE_W-1:0]  age_eff;
    logic                       empty;

    // during a restamp pass the slot's age is its index plus one
    assign age_eff = ctl.renum ? (lsa_pkg::AGE_W'(ctl.idx) + lsa_pkg::AGE_W'(1)) : rd_age;
    assign empty   = (rd_key[lsa_pkg::KEY_W-1 -: 8] == 8'h00);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.en) begin
            if (ctl.idx == '0) begin
                found_reg    <= empty;
                best_idx_reg <= '0;
                best_age_reg <= age_eff;
            end else if (!found_reg) begin
                if (empty) begin
                    found_reg    <= 1'b1;
                    best_idx_reg <= ctl.idx;
                end else if (age_eff < best_age_reg) begin
                    best_idx_reg <= ctl.idx;
                    best_age_reg <= age_eff;
                end
            end
        end
    end

    assign best_idx = best_idx_reg;

endmodule

// File: rtl/core/lsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsa_ctrl
// Sequencer: request intake, restamp/scan walk, slot write and result register.
// ----------------------------------------------------------------------------
module lsa_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsa_pkg::KEY_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsa_pkg::OUT_W-1:0]     m_tdata,
    output lsa_pkg::tbl_wr_t              tbl_wr,
    output lsa_pkg::scan_ctl_t            scan_ctl,
    input  logic [lsa_pkg::SLOT_W-1:0]    best_idx
);

    lsa_pkg::state_t             state_reg, state_next;
    logic [lsa_pkg::SLOT_W-1:0]  idx_reg, idx_next;
    logic [lsa_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [lsa_pkg::AGE_W-1:0]   age_ctr_reg, age_ctr_next;
    logic [lsa_pkg::KEY_W-1:0]   key_reg, key_next;
    logic                        renum_reg, renum_next;
    logic                        full_reg, full_next;
    logic                        m_valid_reg, m_valid_next;
    logic [lsa_pkg::OUT_W-1:0]   m_data_reg, m_data_next;
    logic [lsa_pkg::SLOT_W-1:0]  slot;
    logic [lsa_pkg::AGE_W-1:0]   new_age;

    assign slot    = full_reg ? best_idx : fill_reg[lsa_pkg::SLOT_W-1:0];
    assign new_age = age_ctr_reg + lsa_pkg::AGE_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsa_pkg::ST_IDLE;
            fill_reg    <= '0;
            age_ctr_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            age_ctr_reg <= age_ctr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        renum_reg  <= renum_next;
        full_reg   <= full_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        fill_next    = fill_reg;
        age_ctr_next = age_ctr_reg;
        key_next     = key_reg;
        renum_next   = renum_reg;
        full_next    = full_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        s_tready     = 1'b0;
        tbl_wr       = '0;
        scan_ctl.en    = 1'b0;
        scan_ctl.renum = renum_reg;
        scan_ctl.idx   = idx_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            lsa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    key_next   = lsa_pkg::normalize_key(s_tdata);
                    renum_next = (age_ctr_reg >= lsa_pkg::RENUM_AT);
                    full_next  = (fill_reg > lsa_pkg::FILL_W'(lsa_pkg::LAST_SLOT));
                    idx_next   = '0;
                    if ((age_ctr_reg >= lsa_pkg::RENUM_AT)
                        || (fill_reg > lsa_pkg::FILL_W'(lsa_pkg::LAST_SLOT))) begin
                        state_next = lsa_pkg::ST_SCAN;
                    end else begin
                        state_next = lsa_pkg::ST_WRITE;
                    end
                end
            end
            lsa_pkg::ST_SCAN: begin
                scan_ctl.en = 1'b1;
                if (renum_reg) begin
                    tbl_wr.age_we = 1'b1;
                    tbl_wr.addr   = idx_reg;
                    tbl_wr.age    = lsa_pkg::AGE_W'(idx_reg) + lsa_pkg::AGE_W'(1);
                end
                idx_next = idx_reg + lsa_pkg::SLOT_W'(1);
                if (idx_reg == lsa_pkg::SLOT_W'(lsa_pkg::LAST_SLOT)) begin
                    state_next = lsa_pkg::ST_WRITE;
                    if (renum_reg) begin
                        age_ctr_next = lsa_pkg::AGE_W'(lsa_pkg::NSLOTS);
                    end
                end
            end
            lsa_pkg::ST_WRITE: begin
                if (!m_valid_reg || m_tready) begin
                    tbl_wr.key_we = 1'b1;
                    tbl_wr.age_we = 1'b1;
                    tbl_wr.addr   = slot;
                    tbl_wr.key    = key_reg;
                    tbl_wr.age    = new_age;
                    age_ctr_next  = new_age;
                    if (!full_reg) begin
                        fill_next = fill_reg + lsa_pkg::FILL_W'(1);
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {{(lsa_pkg::OUT_W - lsa_pkg::GRANT_W - 2){1'b0}},
                                    renum_reg, full_reg, lsa_pkg::GRANT_W'(slot)};
                    state_next   = lsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lsa_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= lsa_pkg::FILL_W'(lsa_pkg::NSLOTS))
        else $error("fill count beyond slot count");

    a_age_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        age_ctr_reg <= lsa_pkg::RENUM_AT)
        else $error("age counter passed restamp threshold");

    a_result_from_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == lsa_pkg::ST_WRITE))
        else $error("result raised outside write step");

    a_scan_blocks_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsa_pkg::ST_SCAN) |=> !(s_tvalid && s_tready)
            || (state_reg == lsa_pkg::ST_IDLE))
        else $error("request taken during scan");

endmodule
